/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the golden-section search RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/gss_pkg.sv */
// Package for the golden-section search controller: widths, constants,
// operation and status codes, and the structs passed between modules.
package gss_pkg;

    localparam int GSS_VALUE_WIDTH     = 32;
    localparam int GSS_COEFF_WIDTH     = 32;
    localparam int GSS_TOL_WIDTH       = 31;
    localparam int GSS_COUNT_WIDTH     = 16;
    localparam int GSS_CFG_INDEX_WIDTH = 2;
    localparam int GSS_CFG_DATA_WIDTH  = 31;

    // (3 - sqrt 5)/2 and (sqrt 5 - 1)/2 as unsigned Q0.32
    localparam logic [GSS_COEFF_WIDTH-1:0] GSS_K_LOW  = 32'd1640531527;
    localparam logic [GSS_COEFF_WIDTH-1:0] GSS_K_HIGH = 32'd2654435769;

    localparam logic [GSS_TOL_WIDTH-1:0]   GSS_TOL_RESET   = 31'd66;
    localparam logic [GSS_COUNT_WIDTH-1:0] GSS_LIMIT_RESET = 16'd100;

    localparam logic [GSS_CFG_INDEX_WIDTH-1:0] CFG_TOLERANCE  = 2'd0;
    localparam logic [GSS_CFG_INDEX_WIDTH-1:0] CFG_ITER_LIMIT = 2'd1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    typedef enum logic [1:0] {
        ST_EVAL       = 2'd0,
        ST_DONE       = 2'd1,
        ST_IDLE_REPLY = 2'd2
    } gss_status_t;

    typedef struct packed {
        logic                              operation;
        logic signed [GSS_VALUE_WIDTH-1:0] start_left;
        logic signed [GSS_VALUE_WIDTH-1:0] start_right;
        logic signed [GSS_VALUE_WIDTH-1:0] func_value;
    } gss_item_t;

    typedef struct packed {
        gss_status_t                       status;
        logic signed [GSS_VALUE_WIDTH-1:0] point;
        logic signed [GSS_VALUE_WIDTH-1:0] left_out;
        logic signed [GSS_VALUE_WIDTH-1:0] right_out;
        logic        [GSS_COUNT_WIDTH-1:0] iterations_done;
    } gss_result_t;

    typedef struct packed {
        logic [GSS_TOL_WIDTH-1:0]   tolerance;
        logic [GSS_COUNT_WIDTH-1:0] iteration_limit;
    } gss_cfg_t;

endpackage

/* hw/rtl/gss_probe.sv */
// Probe point unit: near + coeff * (far - near), magnitude rounded half up.
// Depends on gss_pkg for the value and coefficient widths.
module gss_probe (
    input  logic signed [gss_pkg::GSS_VALUE_WIDTH-1:0] near_bound,
    input  logic signed [gss_pkg::GSS_VALUE_WIDTH-1:0] far_bound,
    input  logic        [gss_pkg::GSS_COEFF_WIDTH-1:0] coeff,
    output logic signed [gss_pkg::GSS_VALUE_WIDTH-1:0] probe
);
    import gss_pkg::*;

    localparam int W  = GSS_VALUE_WIDTH;
    localparam int KW = GSS_COEFF_WIDTH;
    localparam int PW = W + KW;

    logic signed [W:0]    diff;
    logic signed [W:0]    mag_full;
    logic                 far_ge_near;
    logic [W-1:0]         mag;
    logic [PW-1:0]        prod;
    logic [PW-1:0]        rounded;
    logic [W-1:0]         step;

    // widen by a guard bit so the span never overflows
    assign diff        = {far_bound[W-1], far_bound} - {near_bound[W-1], near_bound};
    assign far_ge_near = !diff[W];
    assign mag_full    = far_ge_near ? diff : -diff;
    assign mag         = mag_full[W-1:0];
    assign prod        = PW'(mag) * PW'(coeff);
    assign rounded     = prod + (PW'(1) << (KW - 1));
    assign step        = rounded[PW-1:KW];
    assign probe       = far_ge_near ? $signed($unsigned(near_bound) + step)
                                     : $signed($unsigned(near_bound) - step);

endmodule

/* hw/rtl/gss_datapath.sv */
// Search state and the single-pass update for one transaction.
// Depends on gss_pkg and gss_probe; assertions come from assert_macros.svh.
`include "assert_macros.svh"

module gss_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  gss_pkg::gss_item_t    item,
    input  gss_pkg::gss_cfg_t     cfg,
    output gss_pkg::gss_result_t  result
);
    import gss_pkg::*;

    localparam int W = GSS_VALUE_WIDTH;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_LOW  = 3'b010,
        PH_HIGH = 3'b100
    } gss_phase_t;

    logic signed [W-1:0]          left_reg, left_next;
    logic signed [W-1:0]          right_reg, right_next;
    logic signed [W-1:0]          probe_low_reg, probe_low_next;
    logic signed [W-1:0]          probe_high_reg, probe_high_next;
    logic signed [W-1:0]          value_low_reg, value_low_next;
    logic [GSS_COUNT_WIDTH-1:0]   count_reg, count_next;
    gss_phase_t                   phase_reg, phase_next;

    logic                         is_start;
    logic signed [W-1:0]          lo_near, lo_far, lo_probe;
    logic signed [W-1:0]          hi_near, hi_far, hi_probe;
    logic                         request;
    logic signed [W:0]            width_ext;
    logic signed [W:0]            sum_ext;
    logic                         go;

    assign is_start = (item.operation == OP_START);

    // Low unit: start bounds, or [left, mu] after the right edge moves
    assign lo_near = is_start ? item.start_left  : left_reg;
    assign lo_far  = is_start ? item.start_right : probe_high_reg;
    // High unit: start bounds, or [lambda, right] after the left edge moves
    assign hi_near = is_start ? item.start_left  : probe_low_reg;
    assign hi_far  = is_start ? item.start_right : right_reg;

    gss_probe u_probe_low (
        .near_bound (lo_near),
        .far_bound  (lo_far),
        .coeff      (GSS_K_LOW),
        .probe      (lo_probe)
    );

    gss_probe u_probe_high (
        .near_bound (hi_near),
        .far_bound  (hi_far),
        .coeff      (GSS_K_HIGH),
        .probe      (hi_probe)
    );

    always_comb begin
        left_next       = left_reg;
        right_next      = right_reg;
        probe_low_next  = probe_low_reg;
        probe_high_next = probe_high_reg;
        value_low_next  = value_low_reg;
        count_next      = count_reg;
        phase_next      = phase_reg;
        request         = 1'b0;
        result.status   = ST_IDLE_REPLY;
        result.point    = '0;

        if (is_start) begin
            left_next       = item.start_left;
            right_next      = item.start_right;
            count_next      = '0;
            probe_low_next  = lo_probe;
            probe_high_next = hi_probe;
            request         = 1'b1;
        end else begin
            unique case (phase_reg)
                PH_LOW: begin
                    value_low_next = item.func_value;
                    result.status  = ST_EVAL;
                    result.point   = probe_high_reg;
                    phase_next     = PH_HIGH;
                end
                PH_HIGH: begin
                    count_next = count_reg + GSS_COUNT_WIDTH'(1);
                    if (value_low_reg > item.func_value) begin
                        left_next       = probe_low_reg;
                        probe_low_next  = probe_high_reg;
                        probe_high_next = hi_probe;
                    end else begin
                        right_next      = probe_high_reg;
                        probe_high_next = probe_low_reg;
                        probe_low_next  = lo_probe;
                    end
                    request = 1'b1;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // decide whether to keep narrowing on the updated interval
        width_ext = {right_next[W-1], right_next} - {left_next[W-1], left_next};
        sum_ext   = {right_next[W-1], right_next} + {left_next[W-1], left_next};
        go = (right_next > left_next)
             && (width_ext[W-1:0] > {{(W - GSS_TOL_WIDTH){1'b0}}, cfg.tolerance})
             && (count_next < cfg.iteration_limit);
        if (request) begin
            if (go) begin
                result.status = ST_EVAL;
                result.point  = probe_low_next;
                phase_next    = PH_LOW;
            end else begin
                result.status = ST_DONE;
                result.point  = sum_ext[W:1];
                phase_next    = PH_IDLE;
            end
        end

        result.left_out        = left_next;
        result.right_out       = right_next;
        result.iterations_done = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg       <= '0;
            right_reg      <= '0;
            probe_low_reg  <= '0;
            probe_high_reg <= '0;
            value_low_reg  <= '0;
            count_reg      <= '0;
            phase_reg      <= PH_IDLE;
        end else if (advance) begin
            left_reg       <= left_next;
            right_reg      <= right_next;
            probe_low_reg  <= probe_low_next;
            probe_high_reg <= probe_high_next;
            value_low_reg  <= value_low_next;
            count_reg      <= count_next;
            phase_reg      <= phase_next;
        end
    end

    `GSS_ASSERT_IMPLY(a_busy_interval_open, aclk, aresetn, phase_reg != PH_IDLE, right_reg > left_reg)
    `GSS_ASSERT_NEXT(a_low_reply_to_high, aclk, aresetn, advance && !is_start && phase_reg == PH_LOW, phase_reg == PH_HIGH)
    `GSS_ASSERT_NEXT(a_done_goes_idle, aclk, aresetn, advance && result.status == ST_DONE, phase_reg == PH_IDLE)

endmodule

/* hw/rtl/golden_section_search_top.sv */
// Golden-section search controller, top level: handshakes, input and result
// registers, configuration registers. Depends on gss_pkg and gss_datapath.
//
// Takes one transaction per cycle unless m_ready stalls the result register,
// and returns exactly one result per transaction through the input register,
// the update logic (two constant-coefficient 32x32 multipliers for the probe
// points) and the result register. A start loads bounds and, like each
// reply, asks for the next value (f(lambda) first) or reports the midpoint
// and final bounds with status done; a reply while idle gets status idle
// reply. The rate of a search is set by the external function evaluator.
// Write the configuration registers only while no transaction is in flight.
`include "assert_macros.svh"

module golden_section_search_top (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    // configuration
    input  logic                                          cfg_we,
    input  logic [gss_pkg::GSS_CFG_INDEX_WIDTH-1:0]       cfg_index,
    input  logic [gss_pkg::GSS_CFG_DATA_WIDTH-1:0]        cfg_wdata,
    // input channel
    input  logic                                          s_valid,
    output logic                                          s_ready,
    input  logic                                          s_operation,
    input  logic signed [gss_pkg::GSS_VALUE_WIDTH-1:0]    s_start_left,
    input  logic signed [gss_pkg::GSS_VALUE_WIDTH-1:0]    s_start_right,
    input  logic signed [gss_pkg::GSS_VALUE_WIDTH-1:0]    s_func_value,
    // result channel
    output logic                                          m_valid,
    input  logic                                          m_ready,
    output logic [1:0]                                    m_status,
    output logic signed [gss_pkg::GSS_VALUE_WIDTH-1:0]    m_point,
    output logic signed [gss_pkg::GSS_VALUE_WIDTH-1:0]    m_left_out,
    output logic signed [gss_pkg::GSS_VALUE_WIDTH-1:0]    m_right_out,
    output logic [gss_pkg::GSS_COUNT_WIDTH-1:0]           m_iterations_done
);
    import gss_pkg::*;

    gss_cfg_t    cfg_reg;
    gss_item_t   item_reg;
    logic        item_valid_reg;
    gss_result_t result_reg;
    gss_result_t result_next;
    logic        m_valid_reg;
    logic        advance;
    logic        accept;

    // fire the update when an item waits and the result register is free
    assign advance = item_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tolerance       <= GSS_TOL_RESET;
            cfg_reg.iteration_limit <= GSS_LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TOLERANCE:  cfg_reg.tolerance <= cfg_wdata[GSS_TOL_WIDTH-1:0];
                CFG_ITER_LIMIT: cfg_reg.iteration_limit <= cfg_wdata[GSS_COUNT_WIDTH-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.operation   <= s_operation;
            item_reg.start_left  <= s_start_left;
            item_reg.start_right <= s_start_right;
            item_reg.func_value  <= s_func_value;
        end
    end

    gss_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = result_reg.status;
    assign m_point           = result_reg.point;
    assign m_left_out        = result_reg.left_out;
    assign m_right_out       = result_reg.right_out;
    assign m_iterations_done = result_reg.iterations_done;

    `GSS_ASSERT_NEXT(a_advance_fills_result, aclk, aresetn, advance, m_valid_reg)
    `GSS_ASSERT_IMPLY(a_empty_stage_ready, aclk, aresetn, !item_valid_reg, s_ready)
    `GSS_ASSERT_IMPLY(a_status_code_valid, aclk, aresetn, m_valid_reg, m_status == ST_EVAL || m_status == ST_DONE || m_status == ST_IDLE_REPLY)

endmodule
